// ----- design/bpra_pkg.sv -----
package bpra_pkg;

    // Bitmap word geometry: one memory word holds 64 page bits
    localparam int WORD_BITS = 64;
    localparam int BIT_W     = 6;

    localparam int POOL_PAGES_DEF = 4096;

    // Field widths of the streams
    localparam int PAGE_SHIFT = 12;
    localparam int PAGE_NUM_W = 20;
    localparam int COUNT_W    = 13;
    localparam int ADDR_W     = 32;
    localparam int STATUS_W   = 2;
    localparam int IN_DATA_W  = 48;
    localparam int IN_USER_W  = 2;

    // Commands and pools
    localparam logic CMD_ALLOC   = 1'b0;
    localparam logic CMD_FREE    = 1'b1;
    localparam logic POOL_KERNEL = 1'b0;
    localparam logic POOL_USER   = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_ROOM = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd2;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_BASE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_USER_BASE   = 2'd1;

    localparam logic [PAGE_NUM_W-1:0] KERNEL_BASE_RST = 20'd786688;
    localparam logic [PAGE_NUM_W-1:0] USER_BASE_RST   = 20'd0;

    // Outcome of evaluating one bitmap word during the scan
    typedef struct packed {
        logic             hit;
        logic [BIT_W-1:0] hit_bit;
    } find_result_t;

endpackage

// ----- design/bpra_run_finder.sv -----
// Evaluate one bitmap word for the first free run that reaches the wanted
// length, given the free run carried in from the lower words.
module bpra_run_finder #(
    parameter int CNT_W = 13
) (
    input  logic [bpra_pkg::WORD_BITS-1:0] used,
    input  logic [CNT_W-1:0]               carry,
    input  logic [CNT_W-1:0]               cnt,
    output bpra_pkg::find_result_t         result,
    output logic [CNT_W-1:0]               carry_next
);

    localparam int WB    = bpra_pkg::WORD_BITS;
    localparam int BW    = bpra_pkg::BIT_W;
    localparam int CMP_W = (CNT_W > BW + 1) ? CNT_W + 1 : BW + 2;

    // Prefix network: nearest used bit at or below each position
    logic [BW:0][WB-1:0]         has_l;
    logic [BW:0][WB-1:0][BW-1:0] idx_l;
    logic [WB-1:0]               hit_v;
    logic [CMP_W-1:0]            need;
    logic [CMP_W-1:0]            cnt_x;
    logic [CMP_W-1:0]            run_len;
    logic [CMP_W-1:0]            pos;

    always_comb
    begin
        for (int j = 0; j < WB; j++)
        begin
            has_l[0][j] = used[j];
            idx_l[0][j] = BW'(j);
        end
        for (int l = 0; l < BW; l++)
        begin
            for (int j = 0; j < WB; j++)
            begin
                if (j >= (1 << l) && !has_l[l][j])
                begin
                    has_l[l+1][j] = has_l[l][(j >= (1 << l)) ? j - (1 << l) : j];
                    idx_l[l+1][j] = idx_l[l][(j >= (1 << l)) ? j - (1 << l) : j];
                end
                else
                begin
                    has_l[l+1][j] = has_l[l][j];
                    idx_l[l+1][j] = idx_l[l][j];
                end
            end
        end

        // The run completes where its length first equals the count
        need    = CMP_W'(cnt) - CMP_W'(carry);
        cnt_x   = CMP_W'(cnt);
        run_len = '0;
        pos     = '0;
        for (int j = 0; j < WB; j++)
        begin
            run_len  = CMP_W'(j) - CMP_W'(idx_l[BW][j]);
            pos      = CMP_W'(j) + CMP_W'(1);
            hit_v[j] = !used[j] && (has_l[BW][j] ? (run_len == cnt_x) : (pos == need));
        end

        result.hit     = |hit_v;
        result.hit_bit = '0;
        for (int j = WB - 1; j >= 0; j--)
        begin
            if (hit_v[j])
            begin
                result.hit_bit = BW'(j);
            end
        end

        if (has_l[BW][WB-1])
        begin
            carry_next = CNT_W'(CMP_W'(WB - 1) - CMP_W'(idx_l[BW][WB-1]));
        end
        else
        begin
            carry_next = CNT_W'(CMP_W'(carry) + CMP_W'(WB));
        end
    end

endmodule

// ----- design/bitmap_page_run_allocator_core.sv -----
// Two-pool page-run allocator over bitmaps held in one on-chip memory.
// Input stream (s_axis_*): one beat per request. tuser carries the command
// (allocate or free) and the pool (kernel or user); tdata carries the page
// count and, for a free, the page address. Output stream (m_axis_*): one
// beat per request with the status in tuser and the run address in tdata.
// Configuration (cfg_*): writes the base page of either pool; write only
// while no request is in flight. cfg_ready is always high.
// Flow: the block takes one request at a time. A free checks the range,
// then does a read-modify-write of each 64-page word the run touches; a
// request rejected at the check goes straight to its result. An allocate
// first scans the pool from word zero up to the word where the run
// completes, reading one bitmap word per cycle from the single memory
// port, and then marks the run with a read-modify-write per word. The
// next request can be taken as soon as the result shows.
// Reset: both bitmaps are cleared by a sweep that writes one word a cycle
// over all 2 * 2^ceil(log2(POOL_PAGES/64)) words (128 at 4096 pages);
// s_axis_tready stays low until it ends. Stall: a finished result waits in
// the output register; the next request is accepted and worked on
// meanwhile and holds at its end until the output register frees up.
module bitmap_page_run_allocator_core #(
    parameter int POOL_PAGES = bpra_pkg::POOL_PAGES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Input beat
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [12:0] page_count, [44:13] page_address, [47:45] zero
    input  logic [bpra_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // [0] command, [1] pool
    input  logic [bpra_pkg::IN_USER_W-1:0]      s_axis_tuser,
    // Result beat
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [31:0] run_address
    output logic [bpra_pkg::ADDR_W-1:0]         m_axis_tdata,
    // [1:0] status
    output logic [bpra_pkg::STATUS_W-1:0]       m_axis_tuser,
    // Configuration writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bpra_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bpra_pkg::PAGE_NUM_W-1:0]     cfg_data
);

    localparam int WB        = bpra_pkg::WORD_BITS;
    localparam int BW        = bpra_pkg::BIT_W;
    localparam int PN_W      = bpra_pkg::PAGE_NUM_W;
    localparam int CN_W      = bpra_pkg::COUNT_W;
    localparam int MAP_WORDS = (POOL_PAGES + WB - 1) / WB;
    localparam int WIDX_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int IDX_W     = WIDX_W + BW;
    localparam int CNT_W     = $clog2(POOL_PAGES + 1);
    localparam int AW        = WIDX_W + 1;
    localparam int MEM_DEPTH = 2 ** AW;
    localparam int TAIL_BITS = POOL_PAGES - (MAP_WORDS - 1) * WB;

    localparam logic [WIDX_W-1:0] LAST_WORD = WIDX_W'(MAP_WORDS - 1);
    // Bits past the pool end in the last word count as used
    localparam logic [WB-1:0] TAIL_MASK = ~({WB{1'b1}} >> (WB - TAIL_BITS));

    localparam logic [2:0] ST_CLR   = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_CHECK = 3'd2;
    localparam logic [2:0] ST_SCAN  = 3'd3;
    localparam logic [2:0] ST_RD    = 3'd4;
    localparam logic [2:0] ST_MOD   = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    // Control state
    logic [2:0]                       state_reg, state_next;
    logic [AW-1:0]                    clr_addr_reg, clr_addr_next;
    logic                             out_valid_reg, out_valid_next;
    logic [PN_W-1:0]                  kbase_reg, kbase_next;
    logic [PN_W-1:0]                  ubase_reg, ubase_next;

    // Request payload and working registers
    logic                             cmd_reg, cmd_next;
    logic                             pool_reg, pool_next;
    logic [CN_W-1:0]                  count_reg, count_next;
    logic [PN_W-1:0]                  page_reg, page_next;
    logic [CNT_W-1:0]                 cnt_reg, cnt_next;
    logic [CNT_W-1:0]                 carry_reg, carry_next;
    logic [WIDX_W-1:0]                scan_word_reg, scan_word_next;
    logic [WIDX_W-1:0]                proc_word_reg, proc_word_next;
    logic [WIDX_W-1:0]                rmw_word_reg, rmw_word_next;
    logic [IDX_W-1:0]                 lo_reg, lo_next;
    logic [IDX_W-1:0]                 hi_reg, hi_next;
    logic [bpra_pkg::STATUS_W-1:0]    status_reg, status_next;
    logic [bpra_pkg::STATUS_W-1:0]    out_status_reg, out_status_next;
    logic [bpra_pkg::ADDR_W-1:0]      out_addr_reg, out_addr_next;

    // Bitmap memory: kernel pool in the lower half, user pool in the upper
    logic [WB-1:0]                    mem [MEM_DEPTH];
    logic [WB-1:0]                    rdata_reg;
    logic                             mem_we;
    logic                             mem_re;
    logic [AW-1:0]                    mem_waddr;
    logic [AW-1:0]                    mem_raddr;
    logic [WB-1:0]                    mem_wdata;

    // Datapath
    logic [PN_W-1:0]                  base_sel;
    logic [PN_W-1:0]                  free_off;
    logic [PN_W+1:0]                  free_end;
    logic                             range_bad;
    logic                             alloc_bad;
    logic [WB-1:0]                    used_word;
    bpra_pkg::find_result_t           find_res;
    logic [CNT_W-1:0]                 find_carry;
    logic [IDX_W-1:0]                 hit_end;
    logic [IDX_W-1:0]                 hit_start;
    logic [BW-1:0]                    lo_off;
    logic [BW-1:0]                    hi_off;
    logic [WB-1:0]                    run_mask;
    logic [PN_W-1:0]                  run_page;
    logic                             out_load;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_addr_reg;
    assign m_axis_tuser  = out_status_reg;

    assign base_sel  = (pool_reg == bpra_pkg::POOL_USER) ? ubase_reg : kbase_reg;
    assign free_off  = page_reg - base_sel;
    assign free_end  = (PN_W + 2)'(free_off) + (PN_W + 2)'(count_reg);
    assign range_bad = (count_reg == '0) || (page_reg < base_sel) ||
                       (free_end > (PN_W + 2)'(POOL_PAGES));
    assign alloc_bad = (count_reg == '0) || (32'(count_reg) > 32'(POOL_PAGES));

    assign used_word = rdata_reg | ((proc_word_reg == LAST_WORD) ? TAIL_MASK : '0);

    bpra_run_finder #(
        .CNT_W      (CNT_W)
    ) u_finder (
        .used       (used_word),
        .carry      (carry_reg),
        .cnt        (cnt_reg),
        .result     (find_res),
        .carry_next (find_carry)
    );

    assign hit_end   = {proc_word_reg, find_res.hit_bit};
    assign hit_start = hit_end - IDX_W'(cnt_reg) + IDX_W'(1);

    // Bits of the current word that fall inside [lo, hi]
    assign lo_off   = (rmw_word_reg == lo_reg[IDX_W-1:BW]) ? lo_reg[BW-1:0] : '0;
    assign hi_off   = (rmw_word_reg == hi_reg[IDX_W-1:BW]) ? hi_reg[BW-1:0] : '1;
    assign run_mask = ({WB{1'b1}} << lo_off) & ({WB{1'b1}} >> (BW'(WB - 1) - hi_off));

    assign run_page = base_sel + PN_W'(lo_reg);
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || m_axis_tready);

    always_comb
    begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        out_valid_next  = out_valid_reg;
        kbase_next      = kbase_reg;
        ubase_next      = ubase_reg;
        cmd_next        = cmd_reg;
        pool_next       = pool_reg;
        count_next      = count_reg;
        page_next       = page_reg;
        cnt_next        = cnt_reg;
        carry_next      = carry_reg;
        scan_word_next  = scan_word_reg;
        proc_word_next  = proc_word_reg;
        rmw_word_next   = rmw_word_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        status_next     = status_reg;
        out_status_next = out_status_reg;
        out_addr_next   = out_addr_reg;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        mem_waddr       = {pool_reg, rmw_word_reg};
        mem_raddr       = {pool_reg, rmw_word_reg};
        mem_wdata       = '0;

        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                bpra_pkg::CFG_KERNEL_BASE: kbase_next = cfg_data;
                bpra_pkg::CFG_USER_BASE:   ubase_next = cfg_data;
                default:                   ;
            endcase
        end

        // Drop the result once the receiver takes it
        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLR:
            begin
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    cmd_next   = s_axis_tuser[0];
                    pool_next  = s_axis_tuser[1];
                    count_next = s_axis_tdata[CN_W-1:0];
                    page_next  = s_axis_tdata[CN_W+bpra_pkg::ADDR_W-1:
                                              CN_W+bpra_pkg::PAGE_SHIFT];
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (cmd_reg == bpra_pkg::CMD_ALLOC)
                begin
                    if (alloc_bad)
                    begin
                        status_next = bpra_pkg::ST_NO_ROOM;
                        state_next  = ST_DONE;
                    end
                    else
                    begin
                        // Start the scan at word zero of the pool
                        cnt_next       = CNT_W'(count_reg);
                        carry_next     = '0;
                        mem_re         = 1'b1;
                        mem_raddr      = {pool_reg, {WIDX_W{1'b0}}};
                        proc_word_next = '0;
                        scan_word_next = WIDX_W'(1);
                        state_next     = ST_SCAN;
                    end
                end
                else
                begin
                    if (range_bad)
                    begin
                        status_next = bpra_pkg::ST_RANGE;
                        state_next  = ST_DONE;
                    end
                    else
                    begin
                        lo_next       = IDX_W'(free_off);
                        hi_next       = IDX_W'(free_end - (PN_W + 2)'(1));
                        rmw_word_next = free_off[IDX_W-1:BW];
                        status_next   = bpra_pkg::ST_OK;
                        state_next    = ST_RD;
                    end
                end
            end
            ST_SCAN:
            begin
                if (find_res.hit)
                begin
                    lo_next       = hit_start;
                    hi_next       = hit_end;
                    rmw_word_next = hit_start[IDX_W-1:BW];
                    status_next   = bpra_pkg::ST_OK;
                    state_next    = ST_RD;
                end
                else if (proc_word_reg == LAST_WORD)
                begin
                    status_next = bpra_pkg::ST_NO_ROOM;
                    state_next  = ST_DONE;
                end
                else
                begin
                    // Advance: carry the free run and fetch the next word
                    carry_next     = find_carry;
                    mem_re         = 1'b1;
                    mem_raddr      = {pool_reg, scan_word_reg};
                    proc_word_next = scan_word_reg;
                    scan_word_next = scan_word_reg + WIDX_W'(1);
                end
            end
            ST_RD:
            begin
                mem_re     = 1'b1;
                state_next = ST_MOD;
            end
            ST_MOD:
            begin
                mem_we = 1'b1;
                if (cmd_reg == bpra_pkg::CMD_ALLOC)
                begin
                    mem_wdata = rdata_reg | run_mask;
                end
                else
                begin
                    mem_wdata = rdata_reg & ~run_mask;
                end
                if (rmw_word_reg == hi_reg[IDX_W-1:BW])
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    rmw_word_next = rmw_word_reg + WIDX_W'(1);
                    state_next    = ST_RD;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    if (status_reg == bpra_pkg::ST_OK && cmd_reg == bpra_pkg::CMD_ALLOC)
                    begin
                        out_addr_next = {run_page, {bpra_pkg::PAGE_SHIFT{1'b0}}};
                    end
                    else
                    begin
                        out_addr_next = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLR;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
            kbase_reg     <= bpra_pkg::KERNEL_BASE_RST;
            ubase_reg     <= bpra_pkg::USER_BASE_RST;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            out_valid_reg <= out_valid_next;
            kbase_reg     <= kbase_next;
            ubase_reg     <= ubase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        pool_reg       <= pool_next;
        count_reg      <= count_next;
        page_reg       <= page_next;
        cnt_reg        <= cnt_next;
        carry_reg      <= carry_next;
        scan_word_reg  <= scan_word_next;
        proc_word_reg  <= proc_word_next;
        rmw_word_reg   <= rmw_word_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        status_reg     <= status_next;
        out_status_reg <= out_status_next;
        out_addr_reg   <= out_addr_next;
    end

    // Single-port bitmap store, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

`ifndef SYNTHESIS
    // The carried free run never reaches the count without a hit
    a_carry_below_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (carry_reg < cnt_reg))
        else $error("scan carry reached the requested count");

    // The scan only reads; no bitmap write may slip in
    a_scan_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> !mem_we)
        else $error("bitmap written during scan");

    // Read-modify-write never walks past the last word of the run
    a_rmw_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MOD) |-> (rmw_word_reg <= hi_reg[IDX_W-1:BW]))
        else $error("read-modify-write beyond run end");

    // A failed request never reports an address
    a_fail_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser != bpra_pkg::ST_OK) |-> (m_axis_tdata == '0))
        else $error("nonzero address with failing status");
`endif

endmodule
